// ===== sv/sbol_pkg.sv =====
// Shared types and constants of the order-list rank sorter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sbol_pkg;

  localparam int MAX_ORDER_DEF   = 32;
  localparam int MAX_RECORDS_DEF = 32;
  localparam int ID_W  = 32;
  localparam int PAY_W = 16;

  typedef enum logic [1:0] {
    CMD_ORDER       = 2'd0,
    CMD_RECORD      = 2'd1,
    CMD_RECORD_LAST = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] item_id;
    logic [15:0]       payload;
    logic              last_item;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_id;
    logic [15:0]       out_payload;
    logic              out_last;
    logic              dropped;
  } out_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/sbol_front.sv =====
// Front part: classifies input items into commands and queues them.
// Depends on sbol_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbol_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire sbol_pkg::in_t  in_data_i,
  output logic                cmd_valid_o,
  output sbol_pkg::cmd_t      cmd_o,
  input  wire logic           cmd_pop_i
);

  sbol_pkg::cmd_t slot_q [2];
  sbol_pkg::cmd_t new_cmd;
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr, rd;

  always_comb begin
    new_cmd.id      = in_data_i.item_id;
    new_cmd.payload = in_data_i.payload;
    if (!in_data_i.operation) begin
      new_cmd.kind = sbol_pkg::CMD_ORDER;
    end else if (in_data_i.last_item) begin
      new_cmd.kind = sbol_pkg::CMD_RECORD_LAST;
    end else begin
      new_cmd.kind = sbol_pkg::CMD_RECORD;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign wr          = push && !full;
  assign rd          = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sbol_back.sv =====
// Back part: stores order ids and records, ranks them and emits them in order.
// Depends on sbol_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbol_back #(
  parameter int MAX_ORDER   = sbol_pkg::MAX_ORDER_DEF,
  parameter int MAX_RECORDS = sbol_pkg::MAX_RECORDS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire sbol_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  output sbol_pkg::out_t      out_o,
  input  wire logic           out_take_i
);

  localparam int OCW = $clog2(MAX_ORDER + 1);
  localparam int OAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int RCW = $clog2(MAX_RECORDS + 1);
  localparam int RAW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RID0 = 3'd1;
  localparam logic [2:0] S_RID1 = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_E0   = 3'd4;
  localparam logic [2:0] S_E1   = 3'd5;

  logic [sbol_pkg::ID_W-1:0]  order_mem [MAX_ORDER];
  logic [sbol_pkg::ID_W-1:0]  id_mem    [MAX_RECORDS];
  logic [sbol_pkg::PAY_W-1:0] pay_mem   [MAX_RECORDS];
  logic [OCW-1:0]             rank_mem  [MAX_RECORDS];

  logic [sbol_pkg::ID_W-1:0]  ord_rd_q, id_rd_q, cur_id_q, cur_id_d;
  logic [sbol_pkg::PAY_W-1:0] pay_rd_q;
  logic [OCW-1:0]             rank_rd_q;

  logic [2:0]     st_q, st_d;
  logic [OCW-1:0] oc_q, oc_d, scan_q, scan_d, cmp_idx_q, cmp_idx_d, r_q, r_d;
  logic [RCW-1:0] rc_q, rc_d, i_q, i_d, em_q, em_d;
  logic           ovf_q, ovf_d, cmp_v_q, cmp_v_d, ov_q, ov_d;
  sbol_pkg::out_t out_q, out_d;

  logic           ord_we, rec_we, rank_we;
  logic [OCW-1:0] rank_wd;
  logic           slot_free, last_rec;

  assign slot_free   = !ov_q || out_take_i;
  assign last_rec    = (i_q == rc_q - RCW'(1));
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_comb begin
    st_d      = st_q;
    oc_d      = oc_q;
    rc_d      = rc_q;
    ovf_d     = ovf_q;
    scan_d    = scan_q;
    cmp_idx_d = scan_q;
    cmp_v_d   = 1'b0;
    r_d       = r_q;
    i_d       = i_q;
    em_d      = em_q;
    cur_id_d  = cur_id_q;
    ov_d      = ov_q && !out_take_i;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    ord_we    = 1'b0;
    rec_we    = 1'b0;
    rank_we   = 1'b0;
    rank_wd   = oc_q;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == sbol_pkg::CMD_ORDER) begin
            if (oc_q < OCW'(MAX_ORDER)) begin
              ord_we = 1'b1;
              oc_d   = oc_q + OCW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            if (rc_q < RCW'(MAX_RECORDS)) begin
              rec_we = 1'b1;
              rc_d   = rc_q + RCW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            if (cmd_i.kind == sbol_pkg::CMD_RECORD_LAST) begin
              i_d  = '0;
              st_d = S_RID0;
            end
          end
        end
      end
      S_RID0: begin
        st_d = S_RID1;
      end
      S_RID1: begin
        cur_id_d = id_rd_q;
        scan_d   = '0;
        if (oc_q == '0) begin
          rank_we = 1'b1;
          rank_wd = '0;
          if (last_rec) begin
            i_d  = '0;
            r_d  = '0;
            em_d = '0;
            st_d = S_E0;
          end else begin
            i_d  = i_q + RCW'(1);
            st_d = S_RID0;
          end
        end else begin
          st_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q < oc_q) begin
          scan_d  = scan_q + OCW'(1);
          cmp_v_d = 1'b1;
        end
        if (cmp_v_q && (ord_rd_q == cur_id_q || cmp_idx_q == oc_q - OCW'(1))) begin
          rank_we = 1'b1;
          rank_wd = (ord_rd_q == cur_id_q) ? cmp_idx_q : oc_q;
          cmp_v_d = 1'b0;
          if (last_rec) begin
            i_d  = '0;
            r_d  = '0;
            em_d = '0;
            st_d = S_E0;
          end else begin
            i_d  = i_q + RCW'(1);
            st_d = S_RID0;
          end
        end
      end
      S_E0: begin
        st_d = S_E1;
      end
      S_E1: begin
        if (rank_rd_q != r_q || slot_free) begin
          st_d = S_E0;
          if (last_rec) begin
            i_d = '0;
            r_d = r_q + OCW'(1);
          end else begin
            i_d = i_q + RCW'(1);
          end
          if (rank_rd_q == r_q) begin
            ov_d              = 1'b1;
            out_d.out_id      = id_rd_q;
            out_d.out_payload = pay_rd_q;
            out_d.out_last    = (em_q == rc_q - RCW'(1));
            out_d.dropped     = ovf_q;
            em_d              = em_q + RCW'(1);
            if (em_q == rc_q - RCW'(1)) begin
              oc_d  = '0;
              rc_d  = '0;
              ovf_d = 1'b0;
              st_d  = S_IDLE;
            end
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      oc_q    <= '0;
      rc_q    <= '0;
      ovf_q   <= 1'b0;
      cmp_v_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      oc_q    <= oc_d;
      rc_q    <= rc_d;
      ovf_q   <= ovf_d;
      cmp_v_q <= cmp_v_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    r_q       <= r_d;
    i_q       <= i_d;
    em_q      <= em_d;
    cur_id_q  <= cur_id_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_mem[oc_q[OAW-1:0]] <= cmd_i.id;
    end
    ord_rd_q <= order_mem[scan_q[OAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      id_mem[rc_q[RAW-1:0]]  <= cmd_i.id;
      pay_mem[rc_q[RAW-1:0]] <= cmd_i.payload;
    end
    id_rd_q  <= id_mem[i_q[RAW-1:0]];
    pay_rd_q <= pay_mem[i_q[RAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[i_q[RAW-1:0]] <= rank_wd;
    end
    rank_rd_q <= rank_mem[i_q[RAW-1:0]];
  end

endmodule
`default_nettype wire

// ===== sv/sort_by_order_list_rank.sv =====
// Top level of the order-list rank sorter: front classifier plus back engine.
// Depends on sbol_pkg, sbol_front and sbol_back.
//
// Usage: push order-list ids (operation 0), then records (operation 1).
// An item transfers when push is high and full is low. The record with
// last_item set closes the batch. Results come out like a queue: the oldest
// result is on out_data_o while empty is low and transfers when pop is high.
// Items load at one per cycle while the back engine is idle. The closing
// record starts ranking, which reads the order memory entry by entry for
// each record up to a match or the last entry, and skips it for an empty
// order list. Emission sweeps the records once per rank value; the single
// order memory port sets the ranking time and the rank sweep sets the
// emission time. Results of one batch are in ascending rank, ties in
// arrival order; all counts and the drop flag clear after the last result.
// Reset empties the input queue and the output register. A stalled
// receiver holds the back engine; up to two items are still taken
// meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sort_by_order_list_rank #(
  parameter int MAX_ORDER   = sbol_pkg::MAX_ORDER_DEF,
  parameter int MAX_RECORDS = sbol_pkg::MAX_RECORDS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire sbol_pkg::in_t  in_data_i,
  output logic                empty,
  input  wire logic           pop,
  output sbol_pkg::out_t      out_data_o
);

  logic           cmd_valid, cmd_pop, out_valid;
  sbol_pkg::cmd_t cmd;

  sbol_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sbol_back #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid),
    .out_o       (out_data_o),
    .out_take_i  (pop)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire

// ===== tb/tb_sort_by_order_list_rank.sv =====
// Testbench of the order-list rank sorter: random and directed batches are
// pushed, and every popped result is checked against a rank-sort scoreboard.
// Depends on sbol_pkg and the sort_by_order_list_rank top level.
`timescale 1ns / 1ps

class rank_sort_board;
  logic [31:0] ord_ids[$];
  logic [31:0] rec_ids[$];
  logic [15:0] rec_pays[$];
  bit          overflow;
  sbol_pkg::out_t sorted_q[$];
  int          n_err;

  function new();
    n_err = 0;
    overflow = 0;
  endfunction

  function int find_rank(logic [31:0] id);
    int r;
    r = ord_ids.size();
    foreach (ord_ids[i]) begin
      if (ord_ids[i] == id) begin
        r = i;
        break;
      end
    end
    return r;
  endfunction

  function void note_item(sbol_pkg::in_t it);
    int n;
    int ranks[$];
    int cnt;
    sbol_pkg::out_t o;
    if (it.operation == 1'b0) begin
      if (ord_ids.size() < 32) ord_ids.push_back(it.item_id);
      else overflow = 1;
      return;
    end
    if (rec_ids.size() < 32) begin
      rec_ids.push_back(it.item_id);
      rec_pays.push_back(it.payload);
    end else begin
      overflow = 1;
    end
    if (!it.last_item) return;
    n = rec_ids.size();
    foreach (rec_ids[i]) ranks.push_back(find_rank(rec_ids[i]));
    cnt = 0;
    for (int r = 0; r <= ord_ids.size(); r++) begin
      for (int i = 0; i < n; i++) begin
        if (ranks[i] == r) begin
          cnt++;
          o.out_id = rec_ids[i];
          o.out_payload = rec_pays[i];
          o.out_last = (cnt == n);
          o.dropped = overflow;
          sorted_q.push_back(o);
        end
      end
    end
    ord_ids.delete();
    rec_ids.delete();
    rec_pays.delete();
    overflow = 0;
  endfunction

  function void check_result(sbol_pkg::out_t got);
    sbol_pkg::out_t e;
    if (sorted_q.size() == 0) begin
      $error("unexpected result id=%0h", got.out_id);
      n_err++;
      return;
    end
    e = sorted_q.pop_front();
    if (got.out_id !== e.out_id) begin
      $error("out_id expected %0h actual %0h", e.out_id, got.out_id);
      n_err++;
    end
    if (got.out_payload !== e.out_payload) begin
      $error("out_payload expected %0h actual %0h", e.out_payload, got.out_payload);
      n_err++;
    end
    if (got.out_last !== e.out_last) begin
      $error("out_last expected %0b actual %0b", e.out_last, got.out_last);
      n_err++;
    end
    if (got.dropped !== e.dropped) begin
      $error("dropped expected %0b actual %0b", e.dropped, got.dropped);
      n_err++;
    end
  endfunction
endclass

module tb_sort_by_order_list_rank;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  sbol_pkg::in_t  in_data_i = '0;
  sbol_pkg::out_t out_data_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int n_items = 0;
  logic [31:0] id_pool[8];
  rank_sort_board board = new();

  localparam int CYCLE_LIMIT = 2_000_000;

  always #5 clk_i = ~clk_i;

  sort_by_order_list_rank u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .in_data_i(in_data_i), .empty(empty), .pop(pop), .out_data_o(out_data_o)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && pop && !empty) board.check_result(out_data_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic op, input logic [31:0] id,
                           input logic [15:0] pay, input logic last);
    sbol_pkg::in_t it;
    it.operation = op;
    it.item_id = id;
    it.payload = pay;
    it.last_item = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_item(it);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.sorted_q.size() != 0) @(negedge clk_i);
    repeat (2200) @(negedge clk_i);
  endtask

  task automatic random_batch();
    int n_ord;
    int n_rec;
    logic [31:0] id;
    n_ord = ($urandom_range(9) == 0) ? $urandom_range(33, 36) : $urandom_range(0, 8);
    n_rec = ($urandom_range(9) == 0) ? $urandom_range(31, 35) : $urandom_range(1, 8);
    foreach (id_pool[i]) id_pool[i] = $urandom();
    for (int i = 0; i < n_ord; i++)
      send_item(1'b0, id_pool[$urandom_range(7)], 16'($urandom()),
                1'($urandom_range(1)));
    for (int i = 0; i < n_rec; i++) begin
      id = ($urandom_range(4) == 0) ? $urandom() : id_pool[$urandom_range(7)];
      if ($urandom_range(9) == 0)
        send_item(1'b0, id_pool[$urandom_range(7)], 16'($urandom()), 1'b0);
      send_item(1'b1, id, 16'($urandom()), i == n_rec - 1);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(1'b1, 32'h0000_0005, 16'h0001, 1'b0);
    send_item(1'b1, 32'h0000_0003, 16'hFFFF, 1'b1);
    send_item(1'b0, 32'h8000_0000, 16'hAAAA, 1'b1);
    send_item(1'b0, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    send_item(1'b0, 32'h8000_0000, 16'h0000, 1'b0);
    send_item(1'b1, 32'hFFFF_FFFF, 16'h1234, 1'b0);
    send_item(1'b1, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    send_item(1'b1, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_item(1'b1, 32'h0000_0000, 16'h5555, 1'b0);
    send_item(1'b1, 32'h7FFF_FFFF, 16'h0F0F, 1'b1);
    drain();
    for (int i = 0; i < 33; i++) send_item(1'b0, i, 16'h0, 1'b0);
    for (int i = 0; i < 33; i++) send_item(1'b1, 32 - i, 16'(i), i == 32);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 12) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 12) : 0;
      while (n_items < 100 + ph * 65) random_batch();
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (board.n_err == 0 && board.sorted_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
